[design/lrs_pkg.sv]
// Shared constants, widths and saturation helpers for the SGD trainer.
package lrs_pkg;

  localparam int MAX_FEATURES = 64;
  localparam int MAX_BATCH    = 256;

  localparam int FIDX_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CNT_W   = FIDX_W + 1;
  localparam int BATCH_W = $clog2(MAX_BATCH + 1);

  localparam int LR_W   = 16;
  localparam int FC_W   = 7;
  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int MEAN_W = 48;
  localparam int FRAC_W = 16;

  localparam logic [15:0] LR_RESET = 16'd655;
  localparam logic [6:0]  FC_RESET = 7'd64;

  // configuration register indexes
  localparam logic REG_LEARNING_RATE = 1'b0;
  localparam logic REG_FEATURE_COUNT = 1'b1;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_add64 = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh00007FFFFFFFFFFF) begin
      sat48 = {1'b0, {47{1'b1}}};
    end else if (v < -64'sh0000800000000000) begin
      sat48 = {1'b1, 47'd0};
    end else begin
      sat48 = v[47:0];
    end
  endfunction

endpackage

[design/lrs_div.sv]
// Bit-serial signed divider: 64-bit accumulator by the unsigned sample count.
module lrs_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [63:0]                dividend,
  input  logic [lrs_pkg::BATCH_W-1:0]       divisor,
  output logic                              done,
  output logic signed [63:0]                quotient
);
  import lrs_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [5:0]          cnt_r;
  logic                neg_r;
  logic [63:0]         quo_r;
  logic [BATCH_W-1:0]  rem_r;
  logic [BATCH_W-1:0]  div_r;
  logic [BATCH_W:0]    trial;
  logic                ge;
  logic [BATCH_W:0]    diff;

  assign trial = {rem_r, quo_r[63]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= dividend[63];
        quo_r  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[BATCH_W-1:0] : trial[BATCH_W-1:0];
        quo_r <= {quo_r[62:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

[design/linear_regression_sgd_trainer.sv]
// Top level of the mini-batch SGD linear regression trainer.
// A non-final feature is multiplied and accumulated; a last feature adds predict, check,
//   output load and, when training, error, bias sum and a gradient read, multiply, write
//   per feature; a closing batch adds a read, divide, multiply, write per weight and the
//   bias, bounded by the serial divider. One item at a time; after a last feature the
//   next is taken once the result is in the output register. Sync active-low reset clears
//   control, weights and accumulators through valid bits; no clearing pass is needed.
module linear_regression_sgd_trainer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic signed [31:0]  in_feature,
  input  logic signed [31:0]  in_target,
  input  logic                in_last_in_batch,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_prediction,
  output logic                out_was_training,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import lrs_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_ACC     = 4'd2;
  localparam logic [3:0] S_PRED    = 4'd3;
  localparam logic [3:0] S_ERR     = 4'd4;
  localparam logic [3:0] S_BACC    = 4'd5;
  localparam logic [3:0] S_GRD_RD  = 4'd6;
  localparam logic [3:0] S_GRD_MUL = 4'd7;
  localparam logic [3:0] S_GRD_WR  = 4'd8;
  localparam logic [3:0] S_CHK     = 4'd9;
  localparam logic [3:0] S_UPD_RD  = 4'd10;
  localparam logic [3:0] S_UPD_DIV = 4'd11;
  localparam logic [3:0] S_UPD_WT  = 4'd12;
  localparam logic [3:0] S_UPD_MUL = 4'd13;
  localparam logic [3:0] S_UPD_WR  = 4'd14;
  localparam logic [3:0] S_OUT     = 4'd15;

  logic [3:0]               state_r, state_nxt;

  // configuration
  logic [LR_W-1:0]          lr_r;
  logic [FC_W-1:0]          fc_r;
  logic [CNT_W-1:0]         fc_eff;

  // item capture
  logic                     op_r, close_r;
  logic signed [31:0]       feat_r, tgt_r;

  // datapath
  logic [FIDX_W-1:0]        pos_r;
  logic [CNT_W-1:0]         k_r;
  logic [BATCH_W-1:0]       bn_r;
  logic signed [63:0]       ps_r, bacc_r, prod_r, uprod_r;
  logic signed [31:0]       bias_r, pred_r, err_r, val_r;
  logic signed [47:0]       mean_r;

  // memories: weights and gradients use valid bits for their zero reset
  logic signed [31:0]       wmem [MAX_FEATURES];
  logic signed [31:0]       rmem [MAX_FEATURES];
  logic signed [63:0]       gmem [MAX_FEATURES];
  logic [MAX_FEATURES-1:0]  wvld_r, gvld_r;
  logic signed [31:0]       w_rd_r, row_rd_r;
  logic signed [63:0]       g_rd_r;
  logic                     wv_rd_r, gv_rd_r;

  logic                     out_valid_r, out_train_r;
  logic signed [31:0]       out_pred_r;

  logic                     in_xfer, rd_en, is_bias, last_feat, close_now, out_free;
  logic [FIDX_W-1:0]        mem_addr;
  logic signed [31:0]       mul_a, mul_b, w_cur;
  logic signed [63:0]       g_cur, g_new, div_q;
  logic signed [63:0]       upd_new;
  logic                     div_start, div_done;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // 0 acts as 1, anything past the array size is clipped
  always_comb begin
    if (fc_r == '0) begin
      fc_eff = CNT_W'(1);
    end else if (32'(fc_r) > 32'(MAX_FEATURES)) begin
      fc_eff = CNT_W'(MAX_FEATURES);
    end else begin
      fc_eff = CNT_W'(fc_r);
    end
  end

  assign last_feat = !((CNT_W'(pos_r) + CNT_W'(1)) < fc_eff);
  assign close_now = close_r || (32'(bn_r) >= 32'(MAX_BATCH));
  assign is_bias   = (32'(k_r) == 32'(MAX_FEATURES));
  assign mem_addr  = (state_r == S_IDLE) ? pos_r : k_r[FIDX_W-1:0];
  assign rd_en     = in_xfer || (state_r == S_GRD_RD) || (state_r == S_UPD_RD && !is_bias);
  assign w_cur     = wv_rd_r ? w_rd_r : 32'sd0;
  assign g_cur     = gv_rd_r ? g_rd_r : 64'sd0;

  // one shared 32x32 multiplier: dot product terms and gradient terms
  always_comb begin
    if (state_r == S_GRD_MUL) begin
      mul_a = err_r;
      mul_b = row_rd_r;
    end else begin
      mul_a = feat_r;
      mul_b = w_cur;
    end
  end

  assign g_new   = sat_add64(g_cur, prod_r >>> FRAC_W);
  assign upd_new = 64'(sat32(64'(val_r) - (uprod_r >>> FRAC_W)));
  assign div_start = (state_r == S_UPD_DIV);

  lrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (is_bias ? bacc_r : g_cur),
    .divisor  (bn_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // memory ports: one read and one write per memory per cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      w_rd_r   <= wmem[mem_addr];
      row_rd_r <= rmem[mem_addr];
      g_rd_r   <= gmem[mem_addr];
    end
    if (in_xfer) begin
      rmem[pos_r] <= in_feature;
    end
    if (state_r == S_GRD_WR) begin
      gmem[k_r[FIDX_W-1:0]] <= g_new;
    end
    if (state_r == S_UPD_WR && !is_bias) begin
      wmem[k_r[FIDX_W-1:0]] <= upd_new[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_MUL;
      S_MUL:     state_nxt = S_ACC;
      S_ACC:     state_nxt = last_feat ? S_PRED : S_IDLE;
      S_PRED:    state_nxt = op_r ? S_ERR : S_CHK;
      S_ERR:     state_nxt = S_BACC;
      S_BACC:    state_nxt = S_GRD_RD;
      S_GRD_RD:  state_nxt = S_GRD_MUL;
      S_GRD_MUL: state_nxt = S_GRD_WR;
      S_GRD_WR:  state_nxt = ((k_r + CNT_W'(1)) == fc_eff) ? S_CHK : S_GRD_RD;
      S_CHK: begin
        if (close_now && bn_r != '0) begin
          state_nxt = S_UPD_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_UPD_RD:  state_nxt = S_UPD_DIV;
      S_UPD_DIV: state_nxt = S_UPD_WT;
      S_UPD_WT:  if (div_done) state_nxt = S_UPD_MUL;
      S_UPD_MUL: state_nxt = S_UPD_WR;
      S_UPD_WR:  state_nxt = is_bias ? S_OUT : S_UPD_RD;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lr_r        <= LR_RESET;
      fc_r        <= FC_RESET;
      wvld_r      <= '0;
      gvld_r      <= '0;
      bias_r      <= '0;
      bacc_r      <= '0;
      ps_r        <= '0;
      pos_r       <= '0;
      bn_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_LEARNING_RATE: lr_r <= cfg_data;
          REG_FEATURE_COUNT: fc_r <= cfg_data[FC_W-1:0];
          default: ;
        endcase
      end
      // S_OUT reloads the output register itself
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (rd_en) begin
        wv_rd_r <= wvld_r[mem_addr];
        gv_rd_r <= gvld_r[mem_addr];
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            feat_r  <= in_feature;
            tgt_r   <= in_target;
            op_r    <= in_operation;
            close_r <= in_last_in_batch;
          end
        end
        S_MUL: prod_r <= mul_a * mul_b;
        S_ACC: begin
          ps_r <= sat_add64(ps_r, prod_r);
          if (!last_feat) begin
            pos_r <= pos_r + FIDX_W'(1);
          end
        end
        S_PRED: begin
          pred_r <= sat32((ps_r >>> FRAC_W) + 64'(bias_r));
          ps_r   <= '0;
          pos_r  <= '0;
        end
        S_ERR:  err_r <= sat32(64'(pred_r) - 64'(tgt_r));
        S_BACC: begin
          bacc_r <= sat_add64(bacc_r, 64'(err_r));
          bn_r   <= bn_r + BATCH_W'(1);
          k_r    <= '0;
        end
        S_GRD_MUL: prod_r <= mul_a * mul_b;
        S_GRD_WR: begin
          gvld_r[k_r[FIDX_W-1:0]] <= 1'b1;
          k_r <= k_r + CNT_W'(1);
        end
        S_CHK: begin
          k_r <= '0;
          if (close_now && bn_r == '0) begin
            gvld_r <= '0;
            bacc_r <= '0;
          end
        end
        S_UPD_DIV: val_r <= is_bias ? bias_r : w_cur;
        S_UPD_WT:  if (div_done) mean_r <= sat48(div_q);
        S_UPD_MUL: uprod_r <= 64'(mean_r) * 64'($signed({1'b0, lr_r}));
        S_UPD_WR: begin
          if (is_bias) begin
            bias_r <= upd_new[31:0];
            gvld_r <= '0;
            bacc_r <= '0;
            bn_r   <= '0;
          end else begin
            wvld_r[k_r[FIDX_W-1:0]] <= 1'b1;
            k_r <= k_r + CNT_W'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pred_r  <= pred_r;
            out_train_r <= op_r;
            if (close_now) begin
              bn_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_prediction   = out_pred_r;
  assign out_was_training = out_train_r;

endmodule

[design/lrs_checker.sv]
// Port-level checks for the trainer, bound to the top level.
module lrs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_prediction,
  input logic               cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prediction))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in work");

  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port stalled");

endmodule

bind linear_regression_sgd_trainer lrs_checker u_lrs_checker (.*);
